// File: rtl/rtttl_pkg.sv
// Shared types, constants and lookup functions of the ringtone note parser.
`timescale 1ns / 1ps

package rtttl_pkg;

  localparam int unsigned AccW  = 16;
  localparam int unsigned WholeW = 18;
  localparam int unsigned GapW  = 19;
  localparam int unsigned OctW  = 4;
  localparam int unsigned DivCycles = WholeW;

  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChLowD  = 8'h64;
  localparam logic [7:0] ChLowO  = 8'h6F;
  localparam logic [7:0] ChLowB  = 8'h62;

  localparam logic [1:0] RegLengthDiv = 2'd0;
  localparam logic [1:0] RegOctave    = 2'd1;
  localparam logic [1:0] RegTempo     = 2'd2;
  localparam logic [1:0] RegVolume    = 2'd3;

  localparam logic [16:0] MinuteMs = 17'd60000;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } in_word_t;

  typedef struct packed {
    logic [5:0]  note_index;
    logic [11:0] freq_hz;
    logic [9:0]  duty_value;
    logic [18:0] gap_ms;
    logic        is_rest;
    logic        melody_done;
  } out_word_t;

  typedef struct packed {
    logic [7:0]  length_div;
    logic [2:0]  octave;
    logic [15:0] tempo;
    logic [3:0]  volume;
  } cfg_t;

  typedef struct packed {
    logic latch_in;
    logic acc_clear;
    logic acc_add;
    logic set_len;
    logic set_oct;
    logic set_tempo;
    logic load_defaults;
    logic note_clear;
    logic div_start;
    logic div_whole;
    logic note_start;
    logic sharp_inc;
    logic dot_set;
    logic oct_digit;
    logic emit_write;
    logic final_rest;
    logic silent_write;
    logic clear_all;
  } cmd_t;

  typedef struct packed {
    logic is_digit;
    logic is_colon;
    logic is_d;
    logic is_o;
    logic is_b;
    logic is_hash;
    logic is_dot;
    logic is_comma;
    logic eot;
    logic acc_zero;
    logic acc_len_ok;
    logic acc_oct_ok;
    logic pending;
    logic div_done;
    logic out_full;
  } sts_t;

  // One-based semitone position of a note letter within its octave (C is 1); zero means rest.
  function automatic logic [3:0] letter_offset(input logic [7:0] c);
    logic [7:0] lc;
    lc = c;
    if (c >= 8'h41 && c <= 8'h5A) lc = c + 8'd32;
    case (lc)
      8'h63:   letter_offset = 4'd1;
      8'h64:   letter_offset = 4'd3;
      8'h65:   letter_offset = 4'd5;
      8'h66:   letter_offset = 4'd6;
      8'h67:   letter_offset = 4'd8;
      8'h61:   letter_offset = 4'd10;
      8'h62:   letter_offset = 4'd12;
      default: letter_offset = 4'd0;
    endcase
  endfunction

  // Equal-tempered pitch table, C4 at index 1 up to B7 at index 48.
  function automatic logic [11:0] pitch_freq(input logic [5:0] idx);
    case (idx)
      6'd1:  pitch_freq = 12'd262;  6'd2:  pitch_freq = 12'd277;
      6'd3:  pitch_freq = 12'd294;  6'd4:  pitch_freq = 12'd311;
      6'd5:  pitch_freq = 12'd330;  6'd6:  pitch_freq = 12'd349;
      6'd7:  pitch_freq = 12'd370;  6'd8:  pitch_freq = 12'd392;
      6'd9:  pitch_freq = 12'd415;  6'd10: pitch_freq = 12'd440;
      6'd11: pitch_freq = 12'd466;  6'd12: pitch_freq = 12'd494;
      6'd13: pitch_freq = 12'd523;  6'd14: pitch_freq = 12'd554;
      6'd15: pitch_freq = 12'd587;  6'd16: pitch_freq = 12'd622;
      6'd17: pitch_freq = 12'd659;  6'd18: pitch_freq = 12'd698;
      6'd19: pitch_freq = 12'd740;  6'd20: pitch_freq = 12'd784;
      6'd21: pitch_freq = 12'd831;  6'd22: pitch_freq = 12'd880;
      6'd23: pitch_freq = 12'd932;  6'd24: pitch_freq = 12'd988;
      6'd25: pitch_freq = 12'd1047; 6'd26: pitch_freq = 12'd1109;
      6'd27: pitch_freq = 12'd1175; 6'd28: pitch_freq = 12'd1245;
      6'd29: pitch_freq = 12'd1319; 6'd30: pitch_freq = 12'd1397;
      6'd31: pitch_freq = 12'd1480; 6'd32: pitch_freq = 12'd1568;
      6'd33: pitch_freq = 12'd1661; 6'd34: pitch_freq = 12'd1760;
      6'd35: pitch_freq = 12'd1865; 6'd36: pitch_freq = 12'd1976;
      6'd37: pitch_freq = 12'd2093; 6'd38: pitch_freq = 12'd2217;
      6'd39: pitch_freq = 12'd2349; 6'd40: pitch_freq = 12'd2489;
      6'd41: pitch_freq = 12'd2637; 6'd42: pitch_freq = 12'd2794;
      6'd43: pitch_freq = 12'd2960; 6'd44: pitch_freq = 12'd3136;
      6'd45: pitch_freq = 12'd3322; 6'd46: pitch_freq = 12'd3520;
      6'd47: pitch_freq = 12'd3729; 6'd48: pitch_freq = 12'd3951;
      default: pitch_freq = 12'd0;
    endcase
  endfunction

endpackage

// File: rtl/rtttl_ctrl.sv
// Parser sequencer: text phase tracking and per-word command sequencing.
`timescale 1ns / 1ps

module rtttl_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  rtttl_pkg::sts_t sts_i,
  output rtttl_pkg::cmd_t cmd_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StStep = 3'd1;
  localparam logic [2:0] StWdiv = 3'd2;
  localparam logic [2:0] StEdiv = 3'd3;
  localparam logic [2:0] StEmit = 3'd4;
  localparam logic [2:0] StEnd  = 3'd5;

  localparam logic [3:0] PhName   = 4'd0;
  localparam logic [3:0] PhHdrD   = 4'd1;
  localparam logic [3:0] PhDEq    = 4'd2;
  localparam logic [3:0] PhDNum   = 4'd3;
  localparam logic [3:0] PhHdrO   = 4'd4;
  localparam logic [3:0] PhOEq    = 4'd5;
  localparam logic [3:0] PhONum   = 4'd6;
  localparam logic [3:0] PhHdrB   = 4'd7;
  localparam logic [3:0] PhBEq    = 4'd8;
  localparam logic [3:0] PhBNum   = 4'd9;
  localparam logic [3:0] PhNLen   = 4'd10;
  localparam logic [3:0] PhNSharp = 4'd11;
  localparam logic [3:0] PhNDot   = 4'd12;
  localparam logic [3:0] PhNOct   = 4'd13;
  localparam logic [3:0] PhNComma = 4'd14;

  logic [2:0] state_q, state_d;
  logic [3:0] phase_q, phase_d;
  logic       redo_q, redo_d;
  logic       emitted_q, emitted_d;

  always_comb begin
    logic redo, enter, emit;
    cmd_o     = '0;
    state_d   = state_q;
    phase_d   = phase_q;
    redo_d    = redo_q;
    emitted_d = emitted_q;
    redo      = 1'b0;
    enter     = 1'b0;
    emit      = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          emitted_d      = 1'b0;
          state_d        = StStep;
        end
      end
      StStep: begin
        unique case (phase_q)
          PhHdrD: begin
            if (sts_i.is_d) phase_d = PhDEq;
            else begin
              phase_d = PhHdrO;
              redo    = 1'b1;
            end
          end
          PhDEq, PhOEq, PhBEq: begin
            cmd_o.acc_clear = 1'b1;
            phase_d         = phase_q + 4'd1;
          end
          PhDNum: begin
            if (sts_i.is_digit) cmd_o.acc_add = 1'b1;
            else begin
              cmd_o.set_len   = sts_i.acc_len_ok;
              cmd_o.acc_clear = 1'b1;
              phase_d         = PhHdrO;
            end
          end
          PhHdrO: begin
            if (sts_i.is_o) phase_d = PhOEq;
            else begin
              phase_d = PhHdrB;
              redo    = 1'b1;
            end
          end
          PhONum: begin
            if (sts_i.is_digit) cmd_o.acc_add = 1'b1;
            else begin
              cmd_o.set_oct   = sts_i.acc_oct_ok;
              cmd_o.acc_clear = 1'b1;
              phase_d         = PhHdrB;
            end
          end
          PhHdrB: begin
            if (sts_i.is_b) phase_d = PhBEq;
            else begin
              enter = 1'b1;
              redo  = 1'b1;
            end
          end
          PhBNum: begin
            if (sts_i.is_digit) cmd_o.acc_add = 1'b1;
            else begin
              cmd_o.set_tempo = !sts_i.acc_zero;
              enter           = 1'b1;
            end
          end
          PhNLen: begin
            if (sts_i.is_digit) cmd_o.acc_add = 1'b1;
            else begin
              cmd_o.note_start = 1'b1;
              phase_d          = PhNSharp;
            end
          end
          PhNSharp: begin
            phase_d = PhNDot;
            if (sts_i.is_hash) cmd_o.sharp_inc = 1'b1;
            else redo = 1'b1;
          end
          PhNDot: begin
            phase_d = PhNOct;
            if (sts_i.is_dot) cmd_o.dot_set = 1'b1;
            else redo = 1'b1;
          end
          PhNOct: begin
            phase_d = PhNComma;
            if (sts_i.is_digit) cmd_o.oct_digit = 1'b1;
            else redo = 1'b1;
          end
          PhNComma: begin
            emit    = 1'b1;
            phase_d = PhNLen;
            redo    = !sts_i.is_comma && !sts_i.eot;
          end
          default: begin
            phase_d = PhName;
            if (sts_i.is_colon) begin
              cmd_o.load_defaults = 1'b1;
              phase_d             = PhHdrD;
            end
          end
        endcase
        if (enter) begin
          cmd_o.note_clear = 1'b1;
          cmd_o.div_start  = 1'b1;
          cmd_o.div_whole  = 1'b1;
          phase_d          = PhNLen;
          redo_d           = redo;
          state_d          = StWdiv;
        end else if (emit) begin
          cmd_o.div_start = 1'b1;
          emitted_d       = 1'b1;
          redo_d          = redo;
          state_d         = StEdiv;
        end else begin
          state_d = redo ? StStep : StEnd;
        end
      end
      StWdiv: begin
        if (sts_i.div_done) state_d = redo_q ? StStep : StEnd;
      end
      StEdiv: begin
        if (sts_i.div_done) state_d = StEmit;
      end
      StEmit: begin
        if (!sts_i.out_full) begin
          cmd_o.emit_write = 1'b1;
          state_d          = redo_q ? StStep : StEnd;
        end
      end
      StEnd: begin
        if (!sts_i.eot) state_d = StIdle;
        else if (emitted_q) begin
          cmd_o.clear_all = 1'b1;
          phase_d         = PhName;
          state_d         = StIdle;
        end else if (sts_i.pending) begin
          cmd_o.div_start = 1'b1;
          emitted_d       = 1'b1;
          redo_d          = 1'b0;
          state_d         = StEdiv;
        end else if (phase_q == PhNLen && !sts_i.acc_zero) begin
          // Bare length digits: turn them into a pending rest first.
          cmd_o.final_rest = 1'b1;
        end else if (!sts_i.out_full) begin
          cmd_o.silent_write = 1'b1;
          cmd_o.clear_all    = 1'b1;
          phase_d            = PhName;
          state_d            = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign in_stall_o = (state_q != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      phase_q   <= PhName;
      redo_q    <= 1'b0;
      emitted_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      redo_q    <= redo_d;
      emitted_q <= emitted_d;
    end
  end

endmodule

// File: rtl/rtttl_dp.sv
// Parser datapath: byte holding, number accumulation, note fields, divider, result word.
`timescale 1ns / 1ps

module rtttl_dp #(
  parameter int unsigned DUTY_MAX    = 1023,
  parameter int unsigned OCTAVE_LOW  = 4,
  parameter int unsigned OCTAVE_HIGH = 7
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rtttl_pkg::in_word_t  in_data_i,
  input  rtttl_pkg::cfg_t      cfg_i,
  input  rtttl_pkg::cmd_t      cmd_i,
  output rtttl_pkg::sts_t      sts_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output rtttl_pkg::out_word_t out_data_o
);

  localparam int unsigned AccW   = rtttl_pkg::AccW;
  localparam int unsigned WholeW = rtttl_pkg::WholeW;
  localparam int unsigned OctW   = rtttl_pkg::OctW;
  localparam int unsigned CntW   = $clog2(rtttl_pkg::DivCycles);
  localparam logic [CntW-1:0] CntLast = CntW'(rtttl_pkg::DivCycles - 1);
  localparam logic [OctW-1:0] OctLo = OctW'(OCTAVE_LOW);
  localparam logic [OctW-1:0] OctHi = OctW'(OCTAVE_HIGH);
  localparam logic [OctW-1:0] OctRst =
      (6 >= OCTAVE_LOW && 6 <= OCTAVE_HIGH) ? OctW'(6) : OctW'(OCTAVE_LOW);
  localparam logic [9:0] Duty1  = 10'((DUTY_MAX * 1) / 10);
  localparam logic [9:0] Duty2  = 10'((DUTY_MAX * 2) / 10);
  localparam logic [9:0] Duty3  = 10'((DUTY_MAX * 3) / 10);
  localparam logic [9:0] Duty4  = 10'((DUTY_MAX * 4) / 10);
  localparam logic [9:0] Duty5  = 10'((DUTY_MAX * 5) / 10);
  localparam logic [9:0] Duty6  = 10'((DUTY_MAX * 6) / 10);
  localparam logic [9:0] Duty7  = 10'((DUTY_MAX * 7) / 10);
  localparam logic [9:0] Duty8  = 10'((DUTY_MAX * 8) / 10);
  localparam logic [9:0] Duty9  = 10'((DUTY_MAX * 9) / 10);
  localparam logic [9:0] Duty10 = 10'(DUTY_MAX);

  rtttl_pkg::in_word_t  byte_q;
  logic [AccW-1:0]      acc_q;
  logic [WholeW-1:0]    whole_q;
  logic [7:0]           cur_len_q;
  logic [OctW-1:0]      cur_oct_q;
  logic [15:0]          cur_tempo_q;
  logic [3:0]           pend_off_q;
  logic [AccW-1:0]      pend_len_q;
  logic                 pend_dot_q;
  logic [OctW-1:0]      pend_oct_q;
  logic                 pending_q;
  logic                 div_busy_q, div_whole_q;
  logic [CntW-1:0]      div_cnt_q;
  logic [WholeW-1:0]    div_dvd_q;
  logic [15:0]          div_rem_q, div_dsr_q;
  logic [WholeW-1:0]    dur_q;
  logic                 out_valid_q;
  rtttl_pkg::out_word_t out_q;

  logic [7:0]      ch;
  logic [3:0]      digit;
  logic [19:0]     acc_next;
  logic [16:0]     div_sh;
  logic            div_ge;
  logic [WholeW-1:0] quot_next;
  logic [15:0]     dur_dsr;
  logic [3:0]      vol;
  logic [9:0]      duty;
  logic [7:0]      idx_sum;
  logic [5:0]      idx;
  logic [rtttl_pkg::GapW-1:0] dur_full;
  logic            div_done;

  assign ch    = byte_q.char_code;
  assign digit = 4'(ch - rtttl_pkg::ChZero);

  // Multiply by ten as two shifts and an add, add the digit, then saturate.
  assign acc_next = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1) + {16'd0, digit};

  assign div_sh    = {div_rem_q, div_dvd_q[WholeW-1]};
  assign div_ge    = div_sh >= {1'b0, div_dsr_q};
  assign quot_next = {div_dvd_q[WholeW-2:0], div_ge};
  assign div_done  = div_busy_q && (div_cnt_q == CntLast);
  assign dur_dsr   = (pend_len_q != '0) ? pend_len_q : {8'd0, cur_len_q};

  assign sts_o.is_digit   = (ch >= rtttl_pkg::ChZero) && (ch <= rtttl_pkg::ChNine);
  assign sts_o.is_colon   = (ch == rtttl_pkg::ChColon);
  assign sts_o.is_d       = (ch == rtttl_pkg::ChLowD);
  assign sts_o.is_o       = (ch == rtttl_pkg::ChLowO);
  assign sts_o.is_b       = (ch == rtttl_pkg::ChLowB);
  assign sts_o.is_hash    = (ch == rtttl_pkg::ChHash);
  assign sts_o.is_dot     = (ch == rtttl_pkg::ChDot);
  assign sts_o.is_comma   = (ch == rtttl_pkg::ChComma);
  assign sts_o.eot        = byte_q.end_of_text;
  assign sts_o.acc_zero   = (acc_q == '0);
  assign sts_o.acc_len_ok = (acc_q != '0) && (acc_q <= AccW'(255));
  assign sts_o.acc_oct_ok = (acc_q >= AccW'(OCTAVE_LOW)) && (acc_q <= AccW'(OCTAVE_HIGH));
  assign sts_o.pending    = pending_q;
  assign sts_o.div_done   = div_done;
  assign sts_o.out_full   = out_valid_q;

  // Result fields of the pending note.
  always_comb begin
    vol = (cfg_i.volume > 4'd10) ? 4'd10 : cfg_i.volume;
    case (vol)
      4'd1:    duty = Duty1;
      4'd2:    duty = Duty2;
      4'd3:    duty = Duty3;
      4'd4:    duty = Duty4;
      4'd5:    duty = Duty5;
      4'd6:    duty = Duty6;
      4'd7:    duty = Duty7;
      4'd8:    duty = Duty8;
      4'd9:    duty = Duty9;
      4'd10:   duty = Duty10;
      default: duty = 10'd0;
    endcase
    idx_sum = 8'd0;
    if (pend_off_q != 4'd0) begin
      idx_sum = {4'd0, pend_off_q};
      if (pend_oct_q >= OctLo)
        idx_sum = idx_sum + ({4'd0, pend_oct_q - OctLo} << 3)
                          + ({4'd0, pend_oct_q - OctLo} << 2);
    end
    idx = (idx_sum > 8'd48) ? 6'd48 : idx_sum[5:0];
    dur_full = {1'b0, dur_q} + (pend_dot_q ? {2'b0, dur_q[WholeW-1:1]} : '0);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) byte_q <= in_data_i;
    if (cmd_i.div_start) begin
      div_dvd_q <= cmd_i.div_whole ? WholeW'(rtttl_pkg::MinuteMs) : whole_q;
      div_rem_q <= '0;
      div_dsr_q <= cmd_i.div_whole ? (cmd_i.set_tempo ? acc_q : cur_tempo_q) : dur_dsr;
    end else if (div_busy_q) begin
      div_dvd_q <= quot_next;
      div_rem_q <= div_ge ? 16'(div_sh - {1'b0, div_dsr_q}) : div_sh[15:0];
    end
    if (div_done && !div_whole_q) dur_q <= quot_next;
    if (cmd_i.emit_write) begin
      out_q.note_index  <= idx;
      out_q.freq_hz     <= (idx != 6'd0) ? rtttl_pkg::pitch_freq(idx) : 12'd0;
      out_q.duty_value  <= (idx != 6'd0) ? duty : 10'd0;
      out_q.gap_ms      <= (idx != 6'd0) ? dur_full + 19'd1 : dur_full;
      out_q.is_rest     <= (idx == 6'd0);
      out_q.melody_done <= byte_q.end_of_text;
    end else if (cmd_i.silent_write) begin
      out_q.note_index  <= '0;
      out_q.freq_hz     <= '0;
      out_q.duty_value  <= '0;
      out_q.gap_ms      <= '0;
      out_q.is_rest     <= 1'b1;
      out_q.melody_done <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      whole_q     <= '0;
      cur_len_q   <= 8'd4;
      cur_oct_q   <= OctRst;
      cur_tempo_q <= 16'd63;
      pend_off_q  <= '0;
      pend_len_q  <= '0;
      pend_dot_q  <= 1'b0;
      pend_oct_q  <= '0;
      pending_q   <= 1'b0;
      div_busy_q  <= 1'b0;
      div_whole_q <= 1'b0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.acc_clear || cmd_i.note_clear || cmd_i.note_start || cmd_i.clear_all)
        acc_q <= '0;
      else if (cmd_i.acc_add)
        acc_q <= (acc_next > 20'd65535) ? 16'hFFFF : acc_next[15:0];

      if (cmd_i.load_defaults) begin
        cur_len_q   <= (cfg_i.length_div != 8'd0) ? cfg_i.length_div : 8'd1;
        cur_oct_q   <= ({1'b0, cfg_i.octave} >= OctLo && {1'b0, cfg_i.octave} <= OctHi)
                       ? {1'b0, cfg_i.octave} : OctLo;
        cur_tempo_q <= (cfg_i.tempo != 16'd0) ? cfg_i.tempo : 16'd1;
      end
      if (cmd_i.set_len)   cur_len_q   <= acc_q[7:0];
      if (cmd_i.set_oct)   cur_oct_q   <= acc_q[OctW-1:0];
      if (cmd_i.set_tempo) cur_tempo_q <= acc_q;

      if (cmd_i.clear_all) begin
        pend_off_q <= '0;
        pend_len_q <= '0;
        pend_dot_q <= 1'b0;
        pend_oct_q <= '0;
      end else if (cmd_i.note_start || cmd_i.final_rest) begin
        pend_off_q <= cmd_i.note_start ? rtttl_pkg::letter_offset(ch) : 4'd0;
        pend_len_q <= acc_q;
        pend_dot_q <= 1'b0;
        pend_oct_q <= cur_oct_q;
      end else begin
        if (cmd_i.sharp_inc && pend_off_q != 4'd0) pend_off_q <= pend_off_q + 4'd1;
        if (cmd_i.dot_set) pend_dot_q <= 1'b1;
        if (cmd_i.oct_digit)
          pend_oct_q <= (digit >= OctLo && digit <= OctHi) ? digit : cur_oct_q;
      end

      if (cmd_i.clear_all || cmd_i.note_clear || cmd_i.emit_write) pending_q <= 1'b0;
      else if (cmd_i.note_start || cmd_i.final_rest)               pending_q <= 1'b1;

      if (cmd_i.div_start) begin
        div_busy_q  <= 1'b1;
        div_whole_q <= cmd_i.div_whole;
        div_cnt_q   <= '0;
      end else if (div_busy_q) begin
        div_cnt_q <= div_cnt_q + CntW'(1);
        if (div_done) begin
          div_busy_q <= 1'b0;
          if (div_whole_q) whole_q <= {quot_next[15:0], 2'b00};
        end
      end

      if (cmd_i.emit_write || cmd_i.silent_write) out_valid_q <= 1'b1;
      else if (!out_stall_i)                      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/rtttl_note_parser.sv
// Top level of the ringtone note parser: register port, sequencer and datapath.
`timescale 1ns / 1ps

// Reads ringtone text one byte per word and returns at most one note event per
// byte. The first note byte after the header and every byte that closes a note
// run the shared restoring divider, one quotient bit per cycle; a last byte that
// both starts the notes and holds a note runs the divider twice. A new byte is
// taken only once the parser is back in idle. A finished event sits in the
// output register while the next byte is taken; a second event waits until the
// first is taken. The user must write the registers only while the parser is
// idle; the block itself does not enforce this.
module rtttl_note_parser #(
  parameter int unsigned DUTY_MAX    = 1023,
  parameter int unsigned OCTAVE_LOW  = 4,
  parameter int unsigned OCTAVE_HIGH = 7
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  rtttl_pkg::in_word_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output rtttl_pkg::out_word_t out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  rtttl_pkg::cfg_t cfg_q;
  rtttl_pkg::cmd_t cmd;
  rtttl_pkg::sts_t sts;
  logic            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.length_div <= 8'd4;
      cfg_q.octave     <= 3'd6;
      cfg_q.tempo      <= 16'd63;
      cfg_q.volume     <= 4'd10;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        rtttl_pkg::RegLengthDiv: cfg_q.length_div <= pwdata[7:0];
        rtttl_pkg::RegOctave:    cfg_q.octave     <= pwdata[2:0];
        rtttl_pkg::RegTempo:     cfg_q.tempo      <= pwdata[15:0];
        rtttl_pkg::RegVolume:    cfg_q.volume     <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      rtttl_pkg::RegLengthDiv: prdata = {24'd0, cfg_q.length_div};
      rtttl_pkg::RegOctave:    prdata = {29'd0, cfg_q.octave};
      rtttl_pkg::RegTempo:     prdata = {16'd0, cfg_q.tempo};
      rtttl_pkg::RegVolume:    prdata = {28'd0, cfg_q.volume};
      default:                 prdata = 32'd0;
    endcase
  end

  rtttl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rtttl_dp #(
    .DUTY_MAX    (DUTY_MAX),
    .OCTAVE_LOW  (OCTAVE_LOW),
    .OCTAVE_HIGH (OCTAVE_HIGH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
